// ----- hdl/waiter_queue_with_keyed_delete_defines.svh -----
// ---------------------------------------------------------------------------
// Waiter queue assertion macros
// Shared concurrent assertion helpers, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef WAITER_QUEUE_WITH_KEYED_DELETE_DEFINES_SVH
`define WAITER_QUEUE_WITH_KEYED_DELETE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define WQKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication: antecedent at one edge, consequent at the next.
`define WQKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/wqkd_pkg.sv -----
// ---------------------------------------------------------------------------
// Waiter queue package
// Action codes, entry layout and the command broadcast to every cell.
// ---------------------------------------------------------------------------
package wqkd_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef struct packed {
    logic [DATA_W-1:0] lock_id;
    logic [DATA_W-1:0] process_number;
  } entry_t;

  // Broadcast to all cells for one transfer
  typedef struct packed {
    logic              del;
    logic [DATA_W-1:0] key;
    entry_t            data;
  } cmd_t;

endpackage

// ----- hdl/waiter_queue_with_keyed_delete.sv -----
// ---------------------------------------------------------------------------
// Waiter queue with keyed delete
// Bounded FIFO of (lock_id, process_number) entries held in a row of cells.
// ---------------------------------------------------------------------------
// Input channel s_*: one operation per transfer. s_tuser carries the action
// (insert at tail, pop front, delete oldest entry matching process_number).
// Output channel m_*: exactly one result per operation, describing the queue
// after it: front entry (all ones when empty), empty flag, removed and
// overflow flags and occupancy (count modulo 32).
// m_tvalid rises the cycle after a transfer; unstalled throughput is one
// operation per cycle: every cell compares its key and shifts from its right
// neighbor in the same cycle, and the removal marker ripples down the row.
// The result sits in an output register; a new operation is taken in the
// cycle the held result is taken, so a stalled receiver holds s_tready low
// until m_tready returns. Nothing is lost or repeated.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// entry contents are not cleared, only the fill count.
// ---------------------------------------------------------------------------
module waiter_queue_with_keyed_delete #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] lock_id, [63:32] process_number
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [31:0] front_process, [63:32] front_lock,
                                 // [64] is_empty, [65] removed, [66] overflow,
                                 // [71:67] occupancy
);
  import wqkd_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          en;
  action_t       action;
  cmd_t          cmd;
  logic [CW-1:0] count, count_next;
  logic          full, ins_ok, removed_next, empty_next;
  logic [QUEUE_DEPTH:0]   hit;
  entry_t        cur  [QUEUE_DEPTH];
  entry_t        nxt  [QUEUE_DEPTH];
  entry_t        front_next;

  logic [DATA_W-1:0] front_process, front_lock;
  logic              is_empty, removed, overflow;
  logic [OCC_W-1:0]  occupancy;

  assign s_tready = ~m_tvalid | m_tready;
  assign en       = s_tvalid & s_tready;
  assign action   = action_t'(s_tuser);

  assign cmd.del                 = (action == ACT_DELETE);
  assign cmd.key                 = s_tdata[63:32];
  assign cmd.data.lock_id        = s_tdata[31:0];
  assign cmd.data.process_number = s_tdata[63:32];

  assign full   = (count == CW'(QUEUE_DEPTH));
  assign ins_ok = (action == ACT_INSERT) & ~full;
  // pop is a removal that starts at the front cell
  assign hit[0] = (action == ACT_POP) & (count != '0);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t right;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = cur[i];
    end else begin : g_mid
      assign right = cur[i+1];
    end
    wqkd_cell u_cell (
      .clk      (clk),
      .en       (en),
      .cmd      (cmd),
      .occupied (CW'(i) < count),
      .load     (ins_ok & (CW'(i) == count)),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .right    (right),
      .cur      (cur[i]),
      .nxt      (nxt[i])
    );
  end

  assign removed_next = hit[QUEUE_DEPTH];
  assign front_next   = nxt[0];

  always_comb begin
    if (ins_ok) begin
      count_next = count + 1'b1;
    end else if (removed_next) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  assign empty_next = (count_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (en) begin
        count <= count_next;
      end
      if (en) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_process <= empty_next ? '1 : front_next.process_number;
      front_lock    <= empty_next ? '1 : front_next.lock_id;
      is_empty      <= empty_next;
      removed       <= removed_next;
      overflow      <= (action == ACT_INSERT) & full;
      occupancy     <= OCC_W'(count_next);
    end
  end

  assign m_tdata = {occupancy, overflow, removed, is_empty, front_lock, front_process};

`include "waiter_queue_with_keyed_delete_defines.svh"

  `WQKD_ASSERT(a_count_bound, count <= CW'(QUEUE_DEPTH), "fill count above depth")
  `WQKD_ASSERT(a_empty_count, !m_tvalid || (is_empty == (count == '0)), "empty flag mismatch")
  `WQKD_ASSERT(a_flags_excl, !m_tvalid || !(removed && overflow), "removed and overflow together")
  `WQKD_ASSERT_NEXT(a_ins_grow, en && ins_ok, count == CW'($past(count) + 1'b1), "grow failed")
  `WQKD_ASSERT_NEXT(a_rm_shrink, en && removed_next, count + 1'b1 == $past(count), "shrink failed")

endmodule

// ----- hdl/wqkd_cell.sv -----
// ---------------------------------------------------------------------------
// Waiter queue cell
// Holds one entry; compares its process number against the delete key and
// takes its right neighbor's entry when a removal lands at or before it.
// ---------------------------------------------------------------------------
module wqkd_cell (
  input  logic            clk,
  input  logic            en,
  input  wqkd_pkg::cmd_t  cmd,
  input  logic            occupied,
  input  logic            load,
  input  logic            hit_in,
  output logic            hit_out,
  input  wqkd_pkg::entry_t right,
  output wqkd_pkg::entry_t cur,
  output wqkd_pkg::entry_t nxt
);
  import wqkd_pkg::*;

  logic match;

  assign match   = cmd.del & occupied & (cur.process_number == cmd.key);
  // hit travels toward the tail: every cell behind the removed one shifts
  assign hit_out = hit_in | match;

  always_comb begin
    if (hit_out) begin
      nxt = right;
    end else if (load) begin
      nxt = cmd.data;
    end else begin
      nxt = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur <= nxt;
    end
  end

endmodule
